>>> rtl/rcpwc_pkg.sv
// Shared types and constants for the RC pulse width capture filter.
package rcpwc_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CNT_W   = 16;
  localparam int WIDTH_W = 18;
  localparam int REJ_W   = 3;

  localparam logic [CNT_W-1:0]          WRAP_ADD_RST    = 16'd9999;
  localparam logic [CNT_W-1:0]          JUMP_LIMIT_RST  = 16'd500;
  localparam logic [REJ_W-1:0]          MAX_REJECTS_RST = 3'd5;
  localparam logic signed [WIDTH_W-1:0] LAST_WIDTH_RST  = 18'sd1500;

  typedef enum logic [1:0] {
    REG_WRAP_ADD    = 2'd0,
    REG_JUMP_LIMIT  = 2'd1,
    REG_MAX_REJECTS = 2'd2
  } cfg_reg_t;

  // Per-channel state word held in the state RAM.
  typedef struct packed {
    logic                      armed;
    logic [CNT_W-1:0]          rise_cnt;
    logic signed [WIDTH_W-1:0] last_width;
    logic [REJ_W-1:0]          rejects;
  } chan_state_t;

  localparam int STATE_W = $bits(chan_state_t);

  localparam chan_state_t STATE_RST = '{
    armed:      1'b0,
    rise_cnt:   '0,
    last_width: LAST_WIDTH_RST,
    rejects:    '0
  };

endpackage

>>> rtl/rcpwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcpwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rc_pulse_width_capture_filter.sv
// Top level of the RC pulse width capture filter with per-channel spike rejection.
//
//  channel | direction | handshake              | word carries
//  --------+-----------+------------------------+---------------------------------
//  in_     | input     | in_valid / in_ready    | channel, capture count
//  out_    | output    | out_valid / out_ready  | channel, filtered width, held flag
//  cfg_    | input     | cfg_valid / cfg_ready  | register index, write data
//
// One input word per cycle while in_ready is high. The accept edge issues the state RAM
// read; as the word leaves compute, its state is written back and any result registered.
// A one-entry bypass of the last write-back covers back-to-back words on one channel.
// rst_n is synchronous; entry valid flops stand in for the state reset values, so there
// is no clearing pass. out_ready low stalls the compute stage only when it holds a result
// and the output register is full; arming words drain regardless. cfg_ready is always high.
module rc_pulse_width_capture_filter (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              in_channel,
  input  logic [rcpwc_pkg::CNT_W-1:0]             in_capture_count,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [1:0]                              out_channel,
  output logic signed [rcpwc_pkg::WIDTH_W-1:0]    out_pulse_width,
  output logic                                    out_held,
  // configuration channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [1:0]                              cfg_index,
  input  logic [rcpwc_pkg::CNT_W-1:0]             cfg_data
);

  import rcpwc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] wrap_add_r;
  logic [CNT_W-1:0] jump_limit_r;
  logic [REJ_W-1:0] max_rejects_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_add_r    <= WRAP_ADD_RST;
      jump_limit_r  <= JUMP_LIMIT_RST;
      max_rejects_r <= MAX_REJECTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WRAP_ADD:    wrap_add_r    <= cfg_data;
        REG_JUMP_LIMIT:  jump_limit_r  <= cfg_data;
        REG_MAX_REJECTS: max_rejects_r <= cfg_data[REJ_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept and issue the state read
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic             chan_ok;
  logic [CH_AW-1:0] in_addr;

  logic             s1_valid_r;
  logic [1:0]       s1_ch_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             s1_go;
  logic             s1_emit;
  logic             out_free;

  assign in_acc  = in_valid && in_ready;
  // channels past the configured count are swallowed with no effect
  assign chan_ok = (32'(in_channel) < CHANNELS);
  assign in_addr = CH_AW'(in_channel);

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid_r && (!s1_emit || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_acc && chan_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r  <= in_channel;
      s1_cnt_r <= in_capture_count;
    end
  end

  // ---------------------------------------------------------------------------
  // State RAM, entry valid flops and write-back bypass
  // ---------------------------------------------------------------------------
  logic [CH_AW-1:0]    s1_addr;
  logic [STATE_W-1:0]  ram_rdata;
  logic                ram_we;
  chan_state_t         st_nxt;
  logic [CHANNELS-1:0] ent_ok_r;

  logic                wb_valid_r;
  logic [CH_AW-1:0]    wb_addr_r;
  chan_state_t         wb_data_r;

  chan_state_t         cur;

  assign s1_addr = CH_AW'(s1_ch_r);
  assign ram_we  = s1_go;

  rcpwc_ram #(
    .WIDTH (STATE_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (st_nxt),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_ok_r   <= '0;
      wb_valid_r <= 1'b0;
    end else if (ram_we) begin
      ent_ok_r[s1_addr] <= 1'b1;
      wb_valid_r        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      wb_addr_r <= s1_addr;
      wb_data_r <= st_nxt;
    end
  end

  // Latest write always wins: it may have landed the same edge as our read.
  always_comb begin
    if (wb_valid_r && wb_addr_r == s1_addr) begin
      cur = wb_data_r;
    end else if (ent_ok_r[s1_addr]) begin
      cur = chan_state_t'(ram_rdata);
    end else begin
      cur = STATE_RST;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: width and spike filter
  // ---------------------------------------------------------------------------
  logic signed [WIDTH_W-1:0] raw_width;
  logic signed [WIDTH_W:0]   diff;
  logic signed [WIDTH_W:0]   diff_neg;
  logic signed [WIDTH_W:0]   jlim;
  logic                      jump;
  logic                      hold;
  logic signed [WIDTH_W-1:0] width_out;

  always_comb begin
    raw_width = $signed({2'b00, s1_cnt_r}) - $signed({2'b00, cur.rise_cnt});
    if (s1_cnt_r < cur.rise_cnt) begin
      raw_width = raw_width + $signed({2'b00, wrap_add_r});
    end
  end

  assign diff     = {raw_width[WIDTH_W-1], raw_width} -
                    {cur.last_width[WIDTH_W-1], cur.last_width};
  assign diff_neg = -diff;
  assign jlim     = $signed({3'b000, jump_limit_r});
  assign jump     = (diff > jlim) || (diff_neg > jlim);
  assign hold     = jump && (cur.rejects < max_rejects_r);

  assign s1_emit   = cur.armed;
  assign width_out = hold ? cur.last_width : raw_width;

  always_comb begin
    st_nxt = cur;
    if (!cur.armed) begin
      // rising edge: remember the count and arm
      st_nxt.armed    = 1'b1;
      st_nxt.rise_cnt = s1_cnt_r;
    end else begin
      st_nxt.armed      = 1'b0;
      st_nxt.last_width = width_out;
      st_nxt.rejects    = hold ? (cur.rejects + 3'd1) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                      out_valid_r;
  logic [1:0]                out_ch_r;
  logic signed [WIDTH_W-1:0] out_width_r;
  logic                      out_held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_ch_r    <= s1_ch_r;
      out_width_r <= width_out;
      out_held_r  <= hold;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_ch_r;
  assign out_pulse_width = out_width_r;
  assign out_held        = out_held_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_s1_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_ch_r) && $stable(s1_cnt_r))
    else $error("compute stage lost its word during a stall");

  a_entry_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> ent_ok_r[$past(s1_addr)] && wb_valid_r && wb_addr_r == $past(s1_addr))
    else $error("state write not tracked by valid flop or bypass");

  a_bad_chan_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !chan_ok |=> !s1_valid_r)
    else $error("out-of-range channel entered the pipeline");

  a_hold_counts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_emit && hold |-> st_nxt.rejects != '0 && max_rejects_r != '0)
    else $error("held width without a reject count");

  a_arm_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_emit && !out_ready |=> out_valid_r == $past(out_valid_r))
    else $error("arming word touched the output register");

endmodule
